@@ rtl/hcls_pkg.sv @@
// Shared types, character codes and the extension classifier for the request-line classifier.
package hcls_pkg;

    // Request text characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    // Extension tracking: bytes kept after the last dot, and the too-long mark
    localparam logic [2:0] EXT_MAX  = 3'd4;
    localparam logic [2:0] EXT_LONG = 3'd5;

    // Record queue between parser and classifier
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_METHOD = 2'd0,
        PH_SKIP   = 2'd1,
        PH_RES    = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        MIME_NONE = 3'd0,
        MIME_HTML = 3'd1,
        MIME_CSS  = 3'd2,
        MIME_JS   = 3'd3,
        MIME_JPEG = 3'd4,
        MIME_PNG  = 3'd5,
        MIME_ICON = 3'd6
    } t_mime;

    typedef struct packed {
        logic [7:0] req_byte;
        logic       first;
    } t_request;

    typedef struct packed {
        logic [3:0] method_length;
        logic [9:0] resource_length;
        logic       empty_resource;
        logic       client_side;
        t_mime      mime_code;
        logic       overflow;
    } t_result;

    // Raw parse record handed from the parser to the classifier
    typedef struct packed {
        logic [3:0]      method_len;
        logic [9:0]      res_len;
        logic            is_empty;
        logic            is_short;
        logic            dot_any;
        logic            dot_past;
        logic [3:0][7:0] ext_bytes;
        logic [2:0]      ext_count;
        logic            overflow;
    } t_record;

    // Map the text after the last dot to a MIME code
    function automatic t_mime mime_of(input t_record rec);
        t_mime      code;
        logic [15:0] w2;
        logic [23:0] w3;
        logic [31:0] w4;
        w2   = {rec.ext_bytes[0], rec.ext_bytes[1]};
        w3   = {rec.ext_bytes[0], rec.ext_bytes[1], rec.ext_bytes[2]};
        w4   = {rec.ext_bytes[0], rec.ext_bytes[1], rec.ext_bytes[2], rec.ext_bytes[3]};
        code = MIME_NONE;
        if (!rec.is_empty && !rec.is_short && rec.dot_past) begin
            case (rec.ext_count)
                3'd2: begin
                    if (w2 == "js") code = MIME_JS;
                end
                3'd3: begin
                    if (w3 == "css")      code = MIME_CSS;
                    else if (w3 == "jpg") code = MIME_JPEG;
                    else if (w3 == "png") code = MIME_PNG;
                    else if (w3 == "ico") code = MIME_ICON;
                end
                3'd4: begin
                    if (w4 == "html")      code = MIME_HTML;
                    else if (w4 == "jpeg") code = MIME_JPEG;
                end
                default: code = MIME_NONE;
            endcase
        end
        return code;
    endfunction

    // Turn a parse record into the result beat
    function automatic t_result classify(input t_record rec);
        t_result res;
        res.method_length   = rec.method_len;
        res.resource_length = rec.res_len;
        res.empty_resource  = rec.is_empty;
        res.client_side     = rec.is_empty | rec.dot_any;
        res.mime_code       = mime_of(rec);
        res.overflow        = rec.overflow;
        return res;
    endfunction

endpackage

@@ rtl/hcls_front.sv @@
// Byte parser: tracks method, resource, dots and extension, emits one record per request closed by a space.
module hcls_front import hcls_pkg::*; #(
    parameter int METHOD_LIMIT   = 10,
    parameter int RESOURCE_LIMIT = 1023,
    localparam int RES_W         = $clog2(RESOURCE_LIMIT + 1)
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_request i_request,
    output logic     o_push,
    output t_record  o_record
);

    t_phase           r_phase, n_phase, cur_phase;
    logic [3:0]       r_mcnt, n_mcnt, cur_mcnt;
    logic [RES_W-1:0] r_rcnt, n_rcnt, cur_rcnt;
    logic             r_dot_any, n_dot_any, cur_dot_any;
    logic             r_dot_past, n_dot_past, cur_dot_past;
    logic [3:0][7:0]  r_ext, n_ext;
    logic [2:0]       r_ecnt, n_ecnt, cur_ecnt;
    logic             r_ovf, n_ovf, cur_ovf;
    logic [RES_W+9:0] rcnt_wide;
    logic             is_space;
    logic             is_dot;

    // A first beat starts from a cleared parse
    always_comb begin
        cur_phase    = i_request.first ? PH_METHOD : r_phase;
        cur_mcnt     = i_request.first ? '0 : r_mcnt;
        cur_rcnt     = i_request.first ? '0 : r_rcnt;
        cur_dot_any  = i_request.first ? 1'b0 : r_dot_any;
        cur_dot_past = i_request.first ? 1'b0 : r_dot_past;
        cur_ecnt     = i_request.first ? '0 : r_ecnt;
        cur_ovf      = i_request.first ? 1'b0 : r_ovf;
    end

    assign is_space = (i_request.req_byte == CH_SPACE);
    assign is_dot   = (i_request.req_byte == CH_DOT);

    // Next phase
    always_comb begin
        n_phase = cur_phase;
        case (cur_phase)
            PH_METHOD: begin
                if (is_space) n_phase = PH_SKIP;
            end
            PH_SKIP:   n_phase = PH_RES;
            PH_RES: begin
                if (is_space) n_phase = PH_DONE;
            end
            PH_DONE:   n_phase = PH_DONE;
            default:   n_phase = PH_METHOD;
        endcase
    end

    // Counters, dot tracking and extension capture
    always_comb begin
        n_mcnt     = cur_mcnt;
        n_rcnt     = cur_rcnt;
        n_dot_any  = cur_dot_any;
        n_dot_past = cur_dot_past;
        n_ext      = r_ext;
        n_ecnt     = cur_ecnt;
        n_ovf      = cur_ovf;
        case (cur_phase)
            PH_METHOD: begin
                if (!is_space) begin
                    if (cur_mcnt < 4'(METHOD_LIMIT)) n_mcnt = cur_mcnt + 4'd1;
                    else                             n_ovf  = 1'b1;
                end
            end
            PH_RES: begin
                if (!is_space) begin
                    if (is_dot) begin
                        n_dot_any = 1'b1;
                        if (cur_rcnt != '0) begin
                            n_dot_past = 1'b1;
                            n_ecnt     = '0;
                        end
                    end else if (cur_dot_past) begin
                        if (cur_ecnt < EXT_MAX) begin
                            n_ext[cur_ecnt[1:0]] = i_request.req_byte;
                            n_ecnt               = cur_ecnt + 3'd1;
                        end else begin
                            n_ecnt = EXT_LONG;
                        end
                    end
                    if (cur_rcnt < RES_W'(RESOURCE_LIMIT)) n_rcnt = cur_rcnt + RES_W'(1);
                    else                                   n_ovf  = 1'b1;
                end
            end
            default: begin
                n_mcnt = cur_mcnt;
            end
        endcase
    end

    // Build the record at the space that closes the resource
    assign rcnt_wide = (RES_W + 10)'(cur_rcnt);

    always_comb begin
        o_push             = i_valid && (cur_phase == PH_RES) && is_space;
        o_record.method_len = cur_mcnt;
        o_record.res_len    = rcnt_wide[9:0];
        o_record.is_empty   = (cur_rcnt == '0);
        o_record.is_short   = (cur_rcnt < RES_W'(3));
        o_record.dot_any    = cur_dot_any;
        o_record.dot_past   = cur_dot_past;
        o_record.ext_bytes  = r_ext;
        o_record.ext_count  = cur_ecnt;
        o_record.overflow   = cur_ovf;
    end

    // Advance parse state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_METHOD;
            r_mcnt     <= '0;
            r_rcnt     <= '0;
            r_dot_any  <= 1'b0;
            r_dot_past <= 1'b0;
            r_ecnt     <= '0;
            r_ovf      <= 1'b0;
        end else if (i_valid) begin
            r_phase    <= n_phase;
            r_mcnt     <= n_mcnt;
            r_rcnt     <= n_rcnt;
            r_dot_any  <= n_dot_any;
            r_dot_past <= n_dot_past;
            r_ecnt     <= n_ecnt;
            r_ovf      <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_ext <= n_ext;
        end
    end

    a_method_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mcnt <= 4'(METHOD_LIMIT))
        else $error("method count passed its limit");

    a_push_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> r_phase == PH_DONE)
        else $error("record pushed without closing the request");

    a_dot_past: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dot_past |-> r_dot_any)
        else $error("extension dot recorded without any dot");

endmodule

@@ rtl/hcls_queue.sv @@
// Short record queue between the parser and the classifier.
module hcls_queue import hcls_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_record i_data,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_empty,
    output t_record o_data
);

    t_record           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    // Track fill level
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop)      n_count = r_count + QCNT_W'(1);
        else if (!i_push && i_pop) n_count = r_count - QCNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + QPTR_W'(1);
            if (i_pop)  r_rptr <= r_rptr + QPTR_W'(1);
            r_count <= n_count;
        end
    end

    // Store pushed records
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop)
        else $error("record pushed into a full queue");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        QPTR_W'(r_wptr - r_rptr) == QPTR_W'(r_count))
        else $error("queue pointers disagree with fill count");

endmodule

@@ rtl/hcls_back.sv @@
// Classifier and result register: turns queued records into result beats.
module hcls_back import hcls_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_empty,
    input  t_record i_q_data,
    output logic    o_q_pop,
    output logic    o_empty,
    input  logic    i_pop,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;
    logic    load;

    // Refill the result register when it is free or being taken
    assign load    = !r_valid || i_pop;
    assign o_q_pop = load && !i_q_empty;
    assign o_empty = !r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= !i_q_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_result <= classify(i_q_data);
        end
    end

    a_pop_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_valid)
        else $error("record taken from queue but result not held");

endmodule

@@ rtl/http_request_line_classifier.sv @@
// Top level of the HTTP request-line classifier: parser, record queue, classifier.
//
//  channel   direction  handshake            beat
//  request   in         i_push / o_full      i_request (req_byte, first)
//  result    out        o_empty / i_pop      o_result (lengths, flags, mime_code)
//
// One request byte is taken every cycle while o_full is low; the parser updates
// its counters in the cycle the beat is taken.
// The edge that takes the closing space writes the record into the queue; the record
// then moves into the result register once that register is free or being popped.
// The four-entry record queue and the result register let the result side stall
// without holding the byte stream; o_full rises only when all of them are occupied.
// Synchronous active-low reset returns the parser to the method phase and empties
// the queue; no clearing pass is needed.
module http_request_line_classifier import hcls_pkg::*; #(
    parameter int METHOD_LIMIT   = 10,
    parameter int RESOURCE_LIMIT = 1023
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    output logic     o_full,
    input  t_request i_request,
    output logic     o_empty,
    input  logic     i_pop,
    output t_result  o_result
);

    logic    accept;
    logic    rec_push;
    t_record rec_in;
    logic    q_empty;
    logic    q_pop;
    t_record q_data;

    assign accept = i_push && !o_full;

    hcls_front #(
        .METHOD_LIMIT   (METHOD_LIMIT),
        .RESOURCE_LIMIT (RESOURCE_LIMIT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (accept),
        .i_request (i_request),
        .o_push    (rec_push),
        .o_record  (rec_in)
    );

    hcls_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_push),
        .i_data  (rec_in),
        .o_full  (o_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    hcls_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_empty   (o_empty),
        .i_pop     (i_pop),
        .o_result  (o_result)
    );

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the HTTP request-line classifier.
`timescale 1ns / 1ps

module testbench;
    import hcls_pkg::*;

    localparam int METHOD_LIMIT   = 10;
    localparam int RESOURCE_LIMIT = 1023;
    localparam int RESET_CYCLES   = 7;
    localparam int ITEM_COUNT     = 1800;
    localparam int IDLE_PERCENT   = 16;
    localparam int QUIET_FROM     = 1500;
    localparam int QUIET_TO       = 3500;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int EXT_POOL_N     = 12;

    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] DOT_CHAR   = 8'h2E;

    // One request byte waiting for the driver, with an optional hold until drained
    typedef struct {
        t_request req;
        bit       wait_drain;
    } t_backlog_entry;

    logic     i_clk     = 1'b0;
    logic     i_rst_n   = 1'b0;
    logic     i_push    = 1'b0;
    logic     i_pop     = 1'b0;
    t_request i_request = '0;
    logic     o_full;
    logic     o_empty;
    t_result  o_result;

    t_backlog_entry byte_backlog [$];
    t_backlog_entry taken;
    t_result        due_results [$];
    int unsigned    cycle_count = 0;
    int unsigned    mismatch_count = 0;
    bit             start_flag = 1'b0;
    bit             hold_next = 1'b0;

    // Parse state of the predictor
    t_phase      parse_phase = PH_METHOD;
    logic [3:0]  meth_count = '0;
    int unsigned res_count = 0;
    bit          dot_any = 1'b0;
    bit          dot_past = 1'b0;
    logic [7:0]  ext_buf [4];
    logic [2:0]  ext_count = '0;
    bit          overflow_seen = 1'b0;

    // Known extensions and their codes
    string ext_names [7] = '{"html", "css", "js", "jpg", "jpeg", "png", "ico"};
    t_mime ext_codes [7] = '{MIME_HTML, MIME_CSS, MIME_JS, MIME_JPEG, MIME_JPEG,
                             MIME_PNG, MIME_ICON};

    // Extensions offered by the stimulus, near misses among them
    string ext_pool [EXT_POOL_N] = '{"html", "css", "js", "jpg", "jpeg", "png", "ico",
                                     "htm", "JS", "jpegx", "c", "pngs"};

    http_request_line_classifier #(
        .METHOD_LIMIT   (METHOD_LIMIT),
        .RESOURCE_LIMIT (RESOURCE_LIMIT)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (i_push),
        .o_full    (o_full),
        .i_request (i_request),
        .o_empty   (o_empty),
        .i_pop     (i_pop),
        .o_result  (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    task automatic clear_parse();
        parse_phase   = PH_METHOD;
        meth_count    = '0;
        res_count     = 0;
        dot_any       = 1'b0;
        dot_past      = 1'b0;
        ext_count     = '0;
        overflow_seen = 1'b0;
        for (int k = 0; k < 4; k++) ext_buf[k] = '0;
    endtask

    // Look the collected extension up in the table of known names
    function automatic t_mime mime_from_extension();
        bit hit;
        if (res_count < 3 || !dot_past) return MIME_NONE;
        for (int i = 0; i < 7; i++) begin
            if (ext_count == ext_names[i].len()) begin
                hit = 1'b1;
                for (int k = 0; k < ext_names[i].len(); k++) begin
                    if (ext_buf[k] != ext_names[i][k]) hit = 1'b0;
                end
                if (hit) return ext_codes[i];
            end
        end
        return MIME_NONE;
    endfunction

    // Advance the parse by one accepted byte; queue the result it closes
    task automatic parse_request_byte(input t_request r);
        t_result    res;
        logic [7:0] b;
        bit         empty;
        b = r.req_byte;
        if (r.first) clear_parse();
        case (parse_phase)
            PH_METHOD: begin
                if (b == SPACE_CHAR) parse_phase = PH_SKIP;
                else if (meth_count < METHOD_LIMIT) meth_count++;
                else overflow_seen = 1'b1;
            end
            PH_SKIP: begin
                parse_phase = PH_RES;
            end
            PH_RES: begin
                if (b != SPACE_CHAR) begin
                    if (b == DOT_CHAR) begin
                        dot_any = 1'b1;
                        if (res_count > 0) begin
                            dot_past  = 1'b1;
                            ext_count = '0;
                        end
                    end else if (dot_past) begin
                        if (ext_count < 4) begin
                            ext_buf[ext_count[1:0]] = b;
                            ext_count++;
                        end else begin
                            ext_count = 3'd5;
                        end
                    end
                    if (res_count < RESOURCE_LIMIT) res_count++;
                    else overflow_seen = 1'b1;
                end else begin
                    parse_phase         = PH_DONE;
                    empty               = (res_count == 0);
                    res.method_length   = meth_count;
                    res.resource_length = res_count[9:0];
                    res.empty_resource  = empty;
                    res.client_side     = empty | dot_any;
                    res.mime_code       = empty ? MIME_NONE : mime_from_extension();
                    res.overflow        = overflow_seen;
                    due_results.push_back(res);
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string field, input int want, input int got);
        mismatch_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    task automatic check_result(input t_result want, input t_result got);
        if (got.method_length !== want.method_length)
            report_mismatch("method_length", int'(want.method_length),
                            int'(got.method_length));
        if (got.resource_length !== want.resource_length)
            report_mismatch("resource_length", int'(want.resource_length),
                            int'(got.resource_length));
        if (got.empty_resource !== want.empty_resource)
            report_mismatch("empty_resource", int'(want.empty_resource),
                            int'(got.empty_resource));
        if (got.client_side !== want.client_side)
            report_mismatch("client_side", int'(want.client_side), int'(got.client_side));
        if (got.mime_code !== want.mime_code)
            report_mismatch("mime_code", int'(want.mime_code), int'(got.mime_code));
        if (got.overflow !== want.overflow)
            report_mismatch("overflow", int'(want.overflow), int'(got.overflow));
    endtask

    // Monitor: count cycles, check popped beats, predict from pushed beats
    always @(posedge i_clk) begin
        cycle_count++;
        if (i_rst_n) begin
            if (i_pop && !o_empty) begin
                if (due_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result beat, expected none, actual %p",
                             $time, o_result);
                end else begin
                    check_result(due_results.pop_front(), o_result);
                end
            end
            if (i_push && !o_full) begin
                if (byte_backlog.size() != 0) begin
                    taken = byte_backlog.pop_front();
                    parse_request_byte(taken.req);
                end
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("http_request_line_classifier verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------

    function automatic bit idle_now();
        if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
        return $urandom_range(0, 99) < IDLE_PERCENT;
    endfunction

    // Drive reset, request beats and pop at the falling edge
    always @(negedge i_clk) begin
        i_rst_n <= (cycle_count >= RESET_CYCLES);
        if (cycle_count <= RESET_CYCLES || byte_backlog.size() == 0) begin
            i_push <= 1'b0;
        end else if (byte_backlog[0].wait_drain && due_results.size() != 0) begin
            i_push <= 1'b0;
        end else if (idle_now()) begin
            i_push <= 1'b0;
        end else begin
            i_push    <= 1'b1;
            i_request <= byte_backlog[0].req;
        end
        i_pop <= (cycle_count > RESET_CYCLES) && !idle_now();
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic put_byte(input logic [7:0] b);
        t_backlog_entry e;
        e.req.req_byte = b;
        e.req.first    = start_flag;
        e.wait_drain   = hold_next;
        byte_backlog.push_back(e);
        start_flag = 1'b0;
        hold_next  = 1'b0;
    endtask

    task automatic put_text(input string s);
        for (int k = 0; k < s.len(); k++) put_byte(s[k]);
    endtask

    function automatic logic [7:0] any_but_space();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == SPACE_CHAR);
        return b;
    endfunction

    function automatic logic [7:0] path_char();
        case ($urandom_range(0, 9))
            0:       return "/";
            1:       return "_";
            2:       return 8'($urandom_range("0", "9"));
            default: return 8'($urandom_range("a", "z"));
        endcase
    endfunction

    // Long request with a resource of the given length ending in an extension
    task automatic put_long_request(input int res_len, input string ext);
        start_flag = 1'b1;
        hold_next  = 1'b1;
        repeat (METHOD_LIMIT) put_byte(8'($urandom_range("A", "Z")));
        put_text(" /");
        repeat (res_len - ext.len() - 1) put_byte(path_char());
        put_byte(DOT_CHAR);
        put_text(ext);
        put_byte(SPACE_CHAR);
    endtask

    // Mostly well-formed request lines with random content, some broken
    task automatic put_random_request();
        int meth_len;
        int shape;
        start_flag = ($urandom_range(0, 9) != 0);
        hold_next  = ($urandom_range(0, 49) == 0);
        case ($urandom_range(0, 19))
            0:       meth_len = 0;
            1:       meth_len = $urandom_range(METHOD_LIMIT, METHOD_LIMIT + 4);
            default: meth_len = $urandom_range(1, 7);
        endcase
        repeat (meth_len) begin
            if ($urandom_range(0, 3) == 0) put_byte(any_but_space());
            else put_byte(8'($urandom_range("A", "Z")));
        end
        put_byte(SPACE_CHAR);
        // the skipped byte, normally the slash
        if ($urandom_range(0, 6) == 0) put_byte(8'($urandom_range(0, 255)));
        else put_byte("/");
        shape = $urandom_range(0, 99);
        if (shape < 12) begin
            // index page: nothing before the closing space
        end else if (shape < 24) begin
            repeat ($urandom_range(1, 10)) put_byte(any_but_space());
        end else if (shape < 34) begin
            put_byte(DOT_CHAR);
            put_text(ext_pool[$urandom_range(0, EXT_POOL_N - 1)]);
        end else begin
            repeat ($urandom_range(0, 6)) put_byte(path_char());
            if ($urandom_range(0, 3) == 0) begin
                put_byte(DOT_CHAR);
                repeat ($urandom_range(0, 3)) put_byte(path_char());
            end
            if ($urandom_range(0, 9) != 0) begin
                put_byte(DOT_CHAR);
                put_text(ext_pool[$urandom_range(0, EXT_POOL_N - 1)]);
            end
        end
        // truncate now and then; the next request usually cuts in with its first flag
        if ($urandom_range(0, 11) != 0) put_byte(SPACE_CHAR);
        // trailing header bytes after the result are ignored
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)));
    endtask

    initial begin
        int target;

        // Directed: no first flag after reset
        start_flag = 1'b0;
        put_text("G /a ");
        // Directed: space as the first byte, and a space as the skipped byte
        start_flag = 1'b1;
        put_text("   ");
        // Directed: extreme byte values in the method, icon extension
        start_flag = 1'b1;
        put_byte(8'h00);
        put_byte(8'hFF);
        put_text(" /x.ico ");
        // Directed: dot at the start of the resource
        start_flag = 1'b1;
        put_text(" /.js ");

        // Resource one past its limit
        put_long_request(RESOURCE_LIMIT + 1, "js");

        target = ITEM_COUNT;
        while (byte_backlog.size() < target) put_random_request();

        // Wait for the backlog to go out and every result to come back
        while (byte_backlog.size() != 0 || due_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("http_request_line_classifier verification clean");
        end else begin
            $display("http_request_line_classifier verification failed");
        end
        $finish;
    end

endmodule
